@@ rtl/mst_pkg.sv @@
`default_nettype none

package mst_pkg;

   // Table geometry and datapath widths
   localparam int NUM_METRICS_DEF = 32;
   localparam int IDX_W           = 5;
   localparam int KIND_W          = 2;
   localparam int DATA_W          = 64;
   localparam int HALF_W          = DATA_W / 2;

   // Average unit: three partial products plus a final accumulate step, then one
   // quotient bit per cycle
   localparam int MUL_STEPS = 4;
   localparam int DIV_STEPS = DATA_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic {
      REQ_UPDATE = 1'b0,
      REQ_CLEAR  = 1'b1
   } req_code_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_COUNTER = 2'd0,
      KIND_AVERAGE = 2'd1,
      KIND_MAXIMUM = 2'd2,
      KIND_MINIMUM = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_AVG,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      AU_IDLE,
      AU_MUL,
      AU_DIV,
      AU_DONE
   } avg_state_type;

   // Operands for (mult_a * mult_b + addend) / divisor
   typedef struct packed {
      logic [DATA_W-1:0] mult_a;
      logic [DATA_W-1:0] mult_b;
      logic [DATA_W-1:0] addend;
      logic [DATA_W-1:0] divisor;
   } avg_op_type;

endpackage

`default_nettype wire

@@ rtl/mst_if.sv @@
`default_nettype none

// Request channel
interface mst_req_if;
   import mst_pkg::*;

   logic                valid;
   logic                ready;
   logic                req_type;
   logic [IDX_W-1:0]    metric_index;
   logic [KIND_W-1:0]   update_kind;
   logic [DATA_W-1:0]   sample_value;

   modport source (
      output valid, req_type, metric_index, update_kind, sample_value,
      input  ready
   );
   modport sink (
      input  valid, req_type, metric_index, update_kind, sample_value,
      output ready
   );
endinterface

// Response channel
interface mst_rsp_if;
   import mst_pkg::*;

   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   entry_value;
   logic [DATA_W-1:0]   entry_count;

   modport source (
      output valid, entry_value, entry_count,
      input  ready
   );
   modport sink (
      input  valid, entry_value, entry_count,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/mst_ram.sv @@
`default_nettype none

module mst_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/mst_avg.sv @@
`default_nettype none

// Computes ((mult_a * mult_b + addend) mod 2^64) / divisor.
// Low half of the product from three 32x32 partial products on one
// multiplier, then a restoring divider at one quotient bit per cycle.
module mst_avg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  mst_pkg::avg_op_type         op,
   output logic                        done,
   output logic [mst_pkg::DATA_W-1:0]  quotient
);
   import mst_pkg::*;

   avg_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] div_ff, div_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] prod_ff, prod_in;

   logic [HALF_W-1:0] mul_x;
   logic [HALF_W-1:0] mul_y;
   logic [DATA_W:0]   rem_shift;
   logic [DATA_W:0]   rem_diff;

   // Partial product select: lo*lo, lo*hi, hi*lo
   always_comb begin
      if (step_ff == '0) begin
         mul_x = a_ff[HALF_W-1:0];
         mul_y = b_ff[HALF_W-1:0];
      end else if (step_ff == STEP_W'(1)) begin
         mul_x = a_ff[HALF_W-1:0];
         mul_y = b_ff[DATA_W-1:HALF_W];
      end else begin
         mul_x = a_ff[DATA_W-1:HALF_W];
         mul_y = b_ff[HALF_W-1:0];
      end
   end

   // Restoring divide step; acc_ff shifts dividend out and quotient in
   assign rem_shift = {rem_ff, acc_ff[DATA_W-1]};
   assign rem_diff  = rem_shift - {1'b0, div_ff};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      div_in   = div_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      prod_in  = prod_ff;
      done     = 1'b0;

      unique case (state_ff)
         AU_IDLE: begin
            if (start) begin
               a_in     = op.mult_a;
               b_in     = op.mult_b;
               div_in   = op.divisor;
               acc_in   = op.addend;
               rem_in   = '0;
               step_in  = '0;
               state_in = AU_MUL;
            end
         end
         AU_MUL: begin
            prod_in = DATA_W'(mul_x) * DATA_W'(mul_y);
            // accumulate the product registered in the previous cycle
            if (step_ff == STEP_W'(1)) begin
               acc_in = acc_ff + prod_ff;
            end else if (step_ff != '0) begin
               acc_in = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
            end
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               step_in  = '0;
               state_in = AU_DIV;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         AU_DIV: begin
            if (!rem_diff[DATA_W]) begin
               rem_in = rem_diff[DATA_W-1:0];
               acc_in = {acc_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[DATA_W-1:0];
               acc_in = {acc_ff[DATA_W-2:0], 1'b0};
            end
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = AU_DONE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         AU_DONE: begin
            done     = 1'b1;
            state_in = AU_IDLE;
         end
         default: begin
            state_in = AU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AU_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      div_ff  <= div_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      prod_ff <= prod_in;
   end

   assign quotient = acc_ff;

endmodule

`default_nettype wire

@@ rtl/metric_statistics_table.sv @@
// Channel | Role   | Transaction
// req_if  | sink   | req_type, metric_index, update_kind, sample_value
// rsp_if  | source | entry_value, entry_count (one per request)
//
// Counter, maximum and minimum updates pass through the read and done states to the result.
// Clear and out-of-range requests go from accept straight to done; clear drops all entry valid bits.
// Running average adds the average state, where it waits on the one-bit-per-cycle divider.
// A new request is taken once the previous result sits in the output register.
// Reset clears every entry at once through per-entry valid bits.
`default_nettype none

module metric_statistics_table #(
   parameter int NUM_METRICS = mst_pkg::NUM_METRICS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mst_req_if.sink   req_if,
   mst_rsp_if.source rsp_if
);
   import mst_pkg::*;

   localparam int AW    = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;
   localparam int CMP_W = IDX_W + AW;
   localparam int RAM_W = 2 * DATA_W;

   ctrl_state_type         state_ff, state_in;
   logic [AW-1:0]          addr_ff, addr_in;
   logic [KIND_W-1:0]      kind_ff, kind_in;
   logic [DATA_W-1:0]      sample_ff, sample_in;
   logic                   wr_ff, wr_in;
   logic [NUM_METRICS-1:0] valid_ff, valid_in;
   logic [DATA_W-1:0]      res_value_ff, res_value_in;
   logic [DATA_W-1:0]      res_count_ff, res_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [DATA_W-1:0]      rsp_count_ff, rsp_count_in;

   logic                   req_accept;
   logic [CMP_W-1:0]       idx_wide;
   logic                   in_range;
   logic                   ram_rd_en;
   logic                   ram_wr_en;
   logic [RAM_W-1:0]       ram_rd_data;
   logic [DATA_W-1:0]      cur_value;
   logic [DATA_W-1:0]      cur_count;
   logic                   avg_start;
   avg_op_type             avg_op;
   logic                   avg_done;
   logic [DATA_W-1:0]      avg_quot;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign idx_wide     = CMP_W'(req_if.metric_index);
   assign in_range     = (idx_wide < CMP_W'(NUM_METRICS));
   assign ram_rd_en    = req_accept;
   assign ram_wr_en    = (state_ff == ST_DONE) && wr_ff;

   // Entry storage: {count, value}
   mst_ram #(
      .WIDTH (RAM_W),
      .DEPTH (NUM_METRICS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data ({res_count_ff, res_value_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_wide[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // An entry not written since the last clear reads as zero
   assign cur_value = valid_ff[addr_ff] ? ram_rd_data[DATA_W-1:0] : '0;
   assign cur_count = valid_ff[addr_ff] ? ram_rd_data[RAM_W-1:DATA_W] : '0;

   assign avg_op.mult_a  = cur_value;
   assign avg_op.mult_b  = cur_count;
   assign avg_op.addend  = sample_ff;
   assign avg_op.divisor = cur_count + DATA_W'(1);

   mst_avg u_avg (
      .clock    (clock),
      .reset    (reset),
      .start    (avg_start),
      .op       (avg_op),
      .done     (avg_done),
      .quotient (avg_quot)
   );

   // Sequencer: accept, read, fold, write back and post the result; clear and out-of-range skip to the post
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      kind_in      = kind_ff;
      sample_in    = sample_ff;
      wr_in        = wr_ff;
      valid_in     = valid_ff;
      res_value_in = res_value_ff;
      res_count_in = res_count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      avg_start    = 1'b0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               addr_in      = idx_wide[AW-1:0];
               kind_in      = req_if.update_kind;
               sample_in    = req_if.sample_value;
               wr_in        = 1'b0;
               res_value_in = '0;
               res_count_in = '0;
               if (req_if.req_type == REQ_CLEAR) begin
                  valid_in = '0;
                  state_in = ST_DONE;
               end else if (!in_range) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            wr_in        = 1'b1;
            res_value_in = cur_value;
            res_count_in = cur_count;
            state_in     = ST_DONE;
            case (kind_type'(kind_ff))
               KIND_COUNTER: begin
                  res_value_in = cur_value + sample_ff;
               end
               KIND_AVERAGE: begin
                  if (sample_ff != '0) begin
                     res_count_in = avg_op.divisor;
                     if (&cur_count) begin
                        // divisor is 2^64: quotient and count both wrap to zero
                        res_value_in = '0;
                     end else begin
                        avg_start = 1'b1;
                        state_in  = ST_AVG;
                     end
                  end
               end
               KIND_MAXIMUM: begin
                  if (sample_ff != '0 && cur_value < sample_ff) begin
                     res_value_in = sample_ff;
                  end
               end
               default: begin
                  // minimum: a stored zero is empty
                  if (sample_ff != '0 && (cur_value == '0 || cur_value > sample_ff)) begin
                     res_value_in = sample_ff;
                  end
               end
            endcase
         end
         ST_AVG: begin
            if (avg_done) begin
               res_value_in = avg_quot;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (wr_ff) begin
               valid_in[addr_ff] = 1'b1;
            end
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_count_in = res_count_ff;
               wr_in        = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ff        <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ff        <= wr_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      kind_ff      <= kind_in;
      sample_ff    <= sample_in;
      res_value_ff <= res_value_in;
      res_count_ff <= res_count_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.entry_value = rsp_value_ff;
   assign rsp_if.entry_count = rsp_count_ff;

endmodule

`default_nettype wire

@@ rtl/mst_checker.sv @@
`default_nettype none

module mst_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [mst_pkg::DATA_W-1:0]  entry_value,
   input wire logic [mst_pkg::DATA_W-1:0]  entry_count
);
   import mst_pkg::*;

   logic [1:0] outst_ff, outst_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // Requests taken but not yet answered
   always_comb begin
      outst_in = outst_ff;
      if (req_xfer && !rsp_xfer) begin
         outst_in = outst_ff + 2'd1;
      end else if (rsp_xfer && !req_xfer) begin
         outst_in = outst_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   // Out of reset: idle and ready, nothing to deliver
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("not idle after reset");

   // No response without a request behind it
   a_rsp_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outst_ff != 2'd0))
      else $error("response without outstanding request");

   // At most the output register's result is pending when a new request enters
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> (outst_ff <= 2'd1))
      else $error("request taken with work still in flight");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(entry_value) && $stable(entry_count)))
      else $error("stalled response changed");

endmodule

bind metric_statistics_table mst_checker u_mst_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .entry_value (rsp_if.entry_value),
   .entry_count (rsp_if.entry_count)
);

`default_nettype wire

@@ tb/mst_stats_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels, predicts each response from the request stream
// and compares it field by field with the oldest expected response.
module mst_stats_checker
   import mst_pkg::*;
#(
   parameter int NUM_METRICS = NUM_METRICS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mst_req_if          req_mon,
   mst_rsp_if          rsp_mon,
   output int unsigned mismatches,
   output int unsigned awaiting,
   output int unsigned checked
);

   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] count;
   } entry_result_type;

   // Shadow copy of the statistics table
   logic [DATA_W-1:0] value_tbl [NUM_METRICS];
   logic [DATA_W-1:0] count_tbl [NUM_METRICS];

   entry_result_type pending_results [$];

   function automatic void wipe_table();
      for (int i = 0; i < NUM_METRICS; i++) begin
         value_tbl[i] = '0;
         count_tbl[i] = '0;
      end
   endfunction

   // Fold one request into the shadow table; returns the entry after the step
   function automatic entry_result_type apply_request(req_code_type code,
                                                      logic [IDX_W-1:0] idx,
                                                      kind_type kind,
                                                      logic [DATA_W-1:0] sample);
      logic [DATA_W-1:0] cur;
      logic [DATA_W-1:0] cnt;
      logic [DATA_W-1:0] sum;
      logic [DATA_W-1:0] div;
      entry_result_type  res;
      res = '0;
      if (code == REQ_CLEAR) begin
         wipe_table();
         return res;
      end
      // entries past the table read back as zero and change nothing
      if (idx >= NUM_METRICS)
         return res;
      cur = value_tbl[idx];
      cnt = count_tbl[idx];
      case (kind)
         KIND_COUNTER: begin
            value_tbl[idx] = cur + sample;
         end
         KIND_AVERAGE: begin
            // product and sum wrap at 64 bits; a wrapped divisor gives zero
            if (sample != '0) begin
               sum = cur * cnt + sample;
               div = cnt + 1'b1;
               value_tbl[idx] = (div == '0) ? '0 : sum / div;
               count_tbl[idx] = div;
            end
         end
         KIND_MAXIMUM: begin
            if (sample > cur)
               value_tbl[idx] = sample;
         end
         default: begin
            // a stored zero means no minimum seen yet
            if (sample != '0 && (cur == '0 || cur > sample))
               value_tbl[idx] = sample;
         end
      endcase
      res.value = value_tbl[idx];
      res.count = count_tbl[idx];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t: response %0d, %s: got %h, expected %h",
                  $time, checked, what, got, want);
   endtask

   // Responses are retired before requests are booked, so a response in the
   // same cycle as a request can never match that request
   always @(posedge clock) begin
      entry_result_type want;
      if (reset) begin
         wipe_table();
         pending_results.delete();
         mismatches = 0;
         checked    = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response with no request pending",
                               rsp_mon.entry_value, '0);
            end else begin
               want = pending_results.pop_front();
               checked++;
               if (rsp_mon.entry_value !== want.value)
                  report_mismatch("entry_value", rsp_mon.entry_value, want.value);
               if (rsp_mon.entry_count !== want.count)
                  report_mismatch("entry_count", rsp_mon.entry_count, want.count);
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_results.push_back(apply_request(req_code_type'(req_mon.req_type),
                                                    req_mon.metric_index,
                                                    kind_type'(req_mon.update_kind),
                                                    req_mon.sample_value));
      end
      awaiting = pending_results.size();
   end

endmodule

@@ tb/tb_metric_statistics_table.sv @@
`timescale 1ns / 100ps

module tb_metric_statistics_table;
   import mst_pkg::*;

   localparam int RANDOM_ITEMS = 1100;
   localparam int DRAIN_CYCLES = 80;

   logic        clock;
   logic        reset;
   int unsigned mismatches;
   int unsigned awaiting;
   int unsigned checked;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned kind_hits [4];
   int unsigned clear_hits;

   mst_req_if req_bus();
   mst_rsp_if rsp_bus();

   metric_statistics_table u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   mst_stats_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .mismatches (mismatches),
      .awaiting   (awaiting),
      .checked    (checked)
   );

   // 125 MHz clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Response backpressure
   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

   // Present one transaction and hold it until taken; returns at a falling edge
   task automatic send_item(req_code_type code, logic [IDX_W-1:0] idx,
                            kind_type kind, logic [DATA_W-1:0] sample);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid        <= 1'b0;
         req_bus.sample_value <= {$urandom, $urandom};
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= code;
      req_bus.metric_index <= idx;
      req_bus.update_kind  <= kind;
      req_bus.sample_value <= sample;
      if (code == REQ_CLEAR)
         clear_hits++;
      else
         kind_hits[kind]++;
      do
         @(posedge clock);
      while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Mix of zero, small, extreme and full-width samples
   function automatic logic [DATA_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return '0;
         1, 2, 3: return 64'($urandom_range(1000, 1));
         4:       return '1;
         5:       return 64'd1 << $urandom_range(DATA_W - 1);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Mostly updates on a few hot entries so averages build real counts
   task automatic send_random_item();
      logic [IDX_W-1:0] idx;
      kind_type         kind;
      if ($urandom_range(199) < 3) begin
         send_item(REQ_CLEAR, IDX_W'($urandom), kind_type'($urandom_range(3)),
                   {$urandom, $urandom});
         return;
      end
      idx  = ($urandom_range(99) < 60) ? IDX_W'($urandom_range(3)) : IDX_W'($urandom);
      kind = kind_type'($urandom_range(3));
      send_item(REQ_UPDATE, idx, kind, pick_sample());
   endtask

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.req_type     = REQ_UPDATE;
      req_bus.metric_index = '0;
      req_bus.update_kind  = KIND_COUNTER;
      req_bus.sample_value = '0;
      rsp_bus.ready        = 1'b0;
      clear_hits           = 0;
      foreach (kind_hits[k])
         kind_hits[k] = 0;
      send_idle_pct = 33;
      recv_idle_pct = 58;
      reset         = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: clear on an empty table with all other fields set
      send_item(REQ_CLEAR,  '1,     KIND_MINIMUM, '1);
      // counter wraps past 2^64 and keeps the count
      send_item(REQ_UPDATE, 5'd0,  KIND_COUNTER, '1);
      send_item(REQ_UPDATE, 5'd0,  KIND_COUNTER, 64'd1);
      send_item(REQ_UPDATE, 5'd31, KIND_COUNTER, 64'h8000_0000_0000_0000);
      // average: zero sample ignored, then small samples, then a wrapping sum
      send_item(REQ_UPDATE, 5'd1,  KIND_AVERAGE, '0);
      send_item(REQ_UPDATE, 5'd1,  KIND_AVERAGE, 64'd10);
      send_item(REQ_UPDATE, 5'd1,  KIND_AVERAGE, 64'd20);
      send_item(REQ_UPDATE, 5'd1,  KIND_AVERAGE, '1);
      send_item(REQ_UPDATE, 5'd1,  KIND_COUNTER, 64'd5);
      // maximum: smaller and zero samples leave it alone
      send_item(REQ_UPDATE, 5'd2,  KIND_MAXIMUM, 64'd5);
      send_item(REQ_UPDATE, 5'd2,  KIND_MAXIMUM, 64'd3);
      send_item(REQ_UPDATE, 5'd2,  KIND_MAXIMUM, '0);
      send_item(REQ_UPDATE, 5'd2,  KIND_MAXIMUM, '1);
      // minimum: zero on an empty entry is ignored, stored zero means empty
      send_item(REQ_UPDATE, 5'd3,  KIND_MINIMUM, '0);
      send_item(REQ_UPDATE, 5'd3,  KIND_MINIMUM, 64'd200);
      send_item(REQ_UPDATE, 5'd3,  KIND_MINIMUM, 64'd300);
      send_item(REQ_UPDATE, 5'd3,  KIND_MINIMUM, 64'd7);
      send_item(REQ_UPDATE, 5'd3,  KIND_MINIMUM, '1);
      // full-scale average twice: the sum wraps on the second
      send_item(REQ_UPDATE, 5'd30, KIND_AVERAGE, '1);
      send_item(REQ_UPDATE, 5'd30, KIND_AVERAGE, '1);
      // clear a populated table, then read back through no-op updates
      send_item(REQ_CLEAR,  5'd0,  KIND_COUNTER, '0);
      send_item(REQ_UPDATE, 5'd1,  KIND_MAXIMUM, '0);
      send_item(REQ_UPDATE, 5'd30, KIND_AVERAGE, '0);

      // Random traffic across three idle profiles
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 58;
            recv_idle_pct = 33;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_random_item();
      end
      req_bus.valid <= 1'b0;

      // Drain outstanding responses
      wait (awaiting == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d counter, %0d average, %0d maximum, %0d minimum, %0d clear requests.",
               kind_hits[KIND_COUNTER], kind_hits[KIND_AVERAGE],
               kind_hits[KIND_MAXIMUM], kind_hits[KIND_MINIMUM], clear_hits);
      $display("Compared %0d responses under three backpressure profiles, %0d mismatches.",
               checked, mismatches);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/mst_pkg.sv
rtl/mst_if.sv
rtl/mst_ram.sv
rtl/mst_avg.sv
rtl/metric_statistics_table.sv
rtl/mst_checker.sv
tb/mst_stats_checker.sv
tb/tb_metric_statistics_table.sv
